>>> hw/rtl/cosp_pkg.sv
// ---------------------------------------------------------------------------
// CoAP option stream parser package
// Shared types and constants for the byte-serial CoAP parser.
// ---------------------------------------------------------------------------
`default_nettype none

package cosp_pkg;

	localparam int URL_CAPACITY = 64;
	localparam int URL_LEN_W    = $clog2(URL_CAPACITY);

	localparam logic [7:0]  PAYLOAD_MARKER = 8'hFF;
	localparam logic [3:0]  NIB_EXT8       = 4'd13;
	localparam logic [3:0]  NIB_EXT16      = 4'd14;
	localparam logic [3:0]  NIB_RESERVED   = 4'd15;
	localparam logic [16:0] EXT8_BIAS      = 17'd13;
	localparam logic [16:0] EXT16_BIAS     = 17'd269;
	localparam logic [19:0] OPT_URI_PATH   = 20'd11;
	localparam logic [19:0] OPT_CONTENT    = 20'd12;
	localparam logic [7:0]  CHAR_SLASH     = 8'h2F;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FORMAT    = 2'd1,
		ST_TRUNCATED = 2'd2,
		ST_URL_OVF   = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		PH_HEADER    = 4'd0,
		PH_TOKEN     = 4'd1,
		PH_OPT       = 4'd2,
		PH_DELTA_ONE = 4'd3,
		PH_DELTA_HI  = 4'd4,
		PH_DELTA_LO  = 4'd5,
		PH_LEN_ONE   = 4'd6,
		PH_LEN_HI    = 4'd7,
		PH_LEN_LO    = 4'd8,
		PH_VALUE     = 4'd9,
		PH_PAYLOAD   = 4'd10,
		PH_DISCARD   = 4'd11
	} phase_t;

	typedef enum logic [1:0] {
		KIND_OTHER = 2'd0,
		KIND_URL   = 2'd1,
		KIND_CT    = 2'd2
	} kind_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} in_word_t;

	typedef struct packed {
		logic        url_char_valid;
		logic [7:0]  url_char;
		logic        payload_valid;
		logic        message_done;
		status_t     parse_status;
		logic [15:0] content_format;
		logic [7:0]  message_code;
		logic [15:0] message_ident;
	} result_t;

endpackage

`default_nettype wire

>>> hw/rtl/coap_option_stream_parser_core.sv
// ---------------------------------------------------------------------------
// CoAP option stream parser
// Byte-serial CoAP header, token and option decoder with Uri-Path output.
// ---------------------------------------------------------------------------
// Takes one message byte per cycle while m_tready does not stall the output,
// tlast on the final byte, and returns one result word per byte through the
// input register, the decode engine and the result register, in that order.
// Uri-Path bytes come out as URL characters with a '/' before each option,
// limited to URL_CAPACITY-1 characters per message; status is sticky within a
// message and all state clears after the last byte.
`default_nettype none

module coap_option_stream_parser_core
	import cosp_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // data_byte
	input  wire logic       s_tlast,   // last_byte
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [55:0]     m_tdata,   // url_char, parse_status, content_format,
	                                   // message_code, message_ident, zero pad
	output logic [1:0]      m_tuser,   // url_char_valid, payload_valid
	output logic            m_tlast    // message_done
);

	logic     valid_s1;
	in_word_t word_s1;
	logic     room;
	logic     fire;
	result_t  result;

	assign fire = valid_s1 && room;

	cosp_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.take     (room),
		.valid_s1 (valid_s1),
		.word_s1  (word_s1)
	);

	cosp_engine u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.word_s1 (word_s1),
		.result  (result)
	);

	cosp_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.result   (result),
		.room     (room),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

`default_nettype wire

>>> hw/rtl/cosp_in_stage.sv
// ---------------------------------------------------------------------------
// CoAP parser input stage
// Registers one incoming byte word ahead of the decode engine.
// ---------------------------------------------------------------------------
`default_nettype none

module cosp_in_stage
	import cosp_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     s_tvalid,
	output logic          s_tready,
	input  wire logic [7:0] s_tdata,   // data_byte
	input  wire logic     s_tlast,     // last_byte
	input  wire logic     take,
	output logic          valid_s1,
	output in_word_t      word_s1
);

	assign s_tready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			word_s1.data <= s_tdata;
			word_s1.last <= s_tlast;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/cosp_engine.sv
// ---------------------------------------------------------------------------
// CoAP parser decode engine
// Holds the parse state and computes the result for one byte per cycle while fire is high.
// ---------------------------------------------------------------------------
`default_nettype none

module cosp_engine
	import cosp_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic fire,
	input  in_word_t  word_s1,
	output result_t   result
);

	phase_t                 phase_q,    phase_d;
	logic [1:0]             hdr_idx_q,  hdr_idx_d;
	logic [3:0]             tok_rem_q,  tok_rem_d;
	logic [19:0]            opt_num_q,  opt_num_d;
	logic [3:0]             len_nib_q,  len_nib_d;
	logic [7:0]             ext_q,      ext_d;
	logic [16:0]            val_rem_q,  val_rem_d;
	logic [1:0]             val_idx_q,  val_idx_d;
	kind_t                  kind_q,     kind_d;
	logic [15:0]            content_q,  content_d;
	logic [7:0]             code_q,     code_d;
	logic [15:0]            ident_q,    ident_d;
	logic [URL_LEN_W-1:0]   url_len_q,  url_len_d;
	status_t                err_q,      err_d;

	logic        emit_req;
	logic [7:0]  emit_ch;
	logic        url_full;
	logic        add_en;
	logic [16:0] add_val;
	logic [20:0] add_sum;
	logic [19:0] opt_new;

	logic [7:0] b;
	logic [3:0] dnib;
	logic [3:0] lnib;

	assign b    = word_s1.data;
	assign dnib = b[7:4];
	assign lnib = b[3:0];

	assign url_full = url_len_q >= URL_LEN_W'(URL_CAPACITY - 1);
	assign add_sum  = {1'b0, opt_num_q} + 21'(add_val);
	assign opt_new  = add_sum[20] ? '1 : add_sum[19:0];

	// next state
	always_comb begin
		logic do_after;
		logic do_open;
		logic open_phase;
		logic val_dec;

		do_after   = 1'b0;
		do_open    = 1'b0;
		open_phase = 1'b0;
		val_dec    = 1'b0;
		emit_req   = 1'b0;
		emit_ch    = CHAR_SLASH;
		add_en     = 1'b0;
		add_val    = '0;

		phase_d   = phase_q;
		hdr_idx_d = hdr_idx_q;
		tok_rem_d = tok_rem_q;
		opt_num_d = opt_num_q;
		len_nib_d = len_nib_q;
		ext_d     = ext_q;
		val_rem_d = val_rem_q;
		val_idx_d = val_idx_q;
		kind_d    = kind_q;
		content_d = content_q;
		code_d    = code_q;
		ident_d   = ident_q;
		url_len_d = url_len_q;
		err_d     = err_q;

		unique case (phase_q)
			PH_HEADER: begin
				unique case (hdr_idx_q)
					2'd0: tok_rem_d = lnib;
					2'd1: code_d = b;
					2'd2: ident_d = {b, 8'h00};
					default: begin
						ident_d = {ident_q[15:8], b};
						phase_d = (tok_rem_q != 4'd0) ? PH_TOKEN : PH_OPT;
					end
				endcase
				hdr_idx_d = hdr_idx_q + 2'd1;
			end
			PH_TOKEN: begin
				tok_rem_d = tok_rem_q - 4'd1;
				if (tok_rem_d == 4'd0) begin
					phase_d = PH_OPT;
				end
			end
			PH_OPT: begin
				if (b == PAYLOAD_MARKER) begin
					phase_d = PH_PAYLOAD;
				end else begin
					len_nib_d = lnib;
					priority if (dnib == NIB_RESERVED || lnib == NIB_RESERVED) begin
						if (err_d == ST_OK) err_d = ST_FORMAT;
						phase_d = PH_DISCARD;
					end else if (dnib == NIB_EXT8) begin
						phase_d = PH_DELTA_ONE;
					end else if (dnib == NIB_EXT16) begin
						phase_d = PH_DELTA_HI;
					end else begin
						add_en   = 1'b1;
						add_val  = 17'(dnib);
						do_after = 1'b1;
					end
				end
			end
			PH_DELTA_ONE: begin
				add_en   = 1'b1;
				add_val  = 17'(b) + EXT8_BIAS;
				do_after = 1'b1;
			end
			PH_DELTA_HI: begin
				ext_d   = b;
				phase_d = PH_DELTA_LO;
			end
			PH_DELTA_LO: begin
				add_en   = 1'b1;
				add_val  = 17'({ext_q, b}) + EXT16_BIAS;
				do_after = 1'b1;
			end
			PH_LEN_ONE: begin
				val_rem_d = 17'(b) + EXT8_BIAS;
				do_open   = 1'b1;
			end
			PH_LEN_HI: begin
				ext_d   = b;
				phase_d = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				val_rem_d = 17'({ext_q, b}) + EXT16_BIAS;
				do_open   = 1'b1;
			end
			PH_VALUE: begin
				if (kind_q == KIND_URL) begin
					emit_req = 1'b1;
					emit_ch  = b;
				end else if (kind_q == KIND_CT) begin
					if (val_idx_q == 2'd0) begin
						content_d = {8'h00, b};
					end else if (val_idx_q == 2'd1) begin
						content_d = {content_q[7:0], b};
					end
					if (val_idx_q < 2'd2) begin
						val_idx_d = val_idx_q + 2'd1;
					end
				end
				val_dec = 1'b1;
			end
			PH_PAYLOAD: begin
			end
			default: phase_d = PH_DISCARD;
		endcase

		if (add_en) begin
			opt_num_d = opt_new;
		end

		if (do_after) begin
			priority if (len_nib_d == NIB_EXT8) begin
				phase_d = PH_LEN_ONE;
			end else if (len_nib_d == NIB_EXT16) begin
				phase_d = PH_LEN_HI;
			end else begin
				val_rem_d = 17'(len_nib_d);
				do_open   = 1'b1;
			end
		end

		if (do_open) begin
			open_phase = 1'b1;
			priority if (opt_num_d == OPT_URI_PATH) begin
				kind_d   = KIND_URL;
				emit_req = 1'b1;
				emit_ch  = CHAR_SLASH;
			end else if (opt_num_d == OPT_CONTENT) begin
				kind_d    = KIND_CT;
				content_d = '0;
				val_idx_d = '0;
			end else if (opt_num_d[0]) begin
				if (err_d == ST_OK) err_d = ST_FORMAT;
				phase_d = PH_DISCARD;
			end else begin
				kind_d = KIND_OTHER;
			end
		end

		if (emit_req) begin
			if (url_full) begin
				if (err_d == ST_OK) err_d = ST_URL_OVF;
				phase_d = PH_DISCARD;
			end else begin
				url_len_d = url_len_q + URL_LEN_W'(1);
			end
		end

		if (open_phase && phase_d != PH_DISCARD) begin
			phase_d = (val_rem_d != 17'd0) ? PH_VALUE : PH_OPT;
		end

		if (val_dec && phase_d == PH_VALUE) begin
			val_rem_d = val_rem_q - 17'd1;
			if (val_rem_d == 17'd0) begin
				phase_d = PH_OPT;
			end
		end

		if (word_s1.last && err_d == ST_OK && phase_d != PH_OPT &&
		    phase_d != PH_PAYLOAD && phase_d != PH_DISCARD) begin
			err_d = ST_TRUNCATED;
		end
	end

	// outputs
	always_comb begin
		result.url_char_valid = emit_req && !url_full;
		result.url_char       = (emit_req && !url_full) ? emit_ch : 8'h00;
		result.payload_valid  = (phase_q == PH_PAYLOAD);
		result.message_done   = word_s1.last;
		result.parse_status   = err_d;
		result.content_format = content_d;
		result.message_code   = code_d;
		result.message_ident  = ident_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HEADER;
			hdr_idx_q <= '0;
			tok_rem_q <= '0;
			opt_num_q <= '0;
			len_nib_q <= '0;
			ext_q     <= '0;
			val_rem_q <= '0;
			val_idx_q <= '0;
			kind_q    <= KIND_OTHER;
			content_q <= '0;
			code_q    <= '0;
			ident_q   <= '0;
			url_len_q <= '0;
			err_q     <= ST_OK;
		end else if (fire) begin
			if (word_s1.last) begin
				phase_q   <= PH_HEADER;
				hdr_idx_q <= '0;
				tok_rem_q <= '0;
				opt_num_q <= '0;
				len_nib_q <= '0;
				ext_q     <= '0;
				val_rem_q <= '0;
				val_idx_q <= '0;
				kind_q    <= KIND_OTHER;
				content_q <= '0;
				code_q    <= '0;
				ident_q   <= '0;
				url_len_q <= '0;
				err_q     <= ST_OK;
			end else begin
				phase_q   <= phase_d;
				hdr_idx_q <= hdr_idx_d;
				tok_rem_q <= tok_rem_d;
				opt_num_q <= opt_num_d;
				len_nib_q <= len_nib_d;
				ext_q     <= ext_d;
				val_rem_q <= val_rem_d;
				val_idx_q <= val_idx_d;
				kind_q    <= kind_d;
				content_q <= content_d;
				code_q    <= code_d;
				ident_q   <= ident_d;
				url_len_q <= url_len_d;
				err_q     <= err_d;
			end
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/cosp_out_stage.sv
// ---------------------------------------------------------------------------
// CoAP parser output stage
// Result register and master-side stream packing.
// ---------------------------------------------------------------------------
`default_nettype none

module cosp_out_stage
	import cosp_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  fire,
	input  result_t    result,
	output logic       room,
	output logic       m_tvalid,
	input  wire logic  m_tready,
	output logic [55:0] m_tdata,  // url_char, parse_status, content_format,
	                              // message_code, message_ident, zero pad
	output logic [1:0] m_tuser,   // url_char_valid, payload_valid
	output logic       m_tlast    // message_done
);

	result_t res_s2;

	assign room = !m_tvalid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (room) begin
			m_tvalid <= fire;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= result;
		end
	end

	assign m_tdata = {6'b0, res_s2.message_ident, res_s2.message_code,
	                  res_s2.content_format, res_s2.parse_status, res_s2.url_char};
	assign m_tuser = {res_s2.payload_valid, res_s2.url_char_valid};
	assign m_tlast = res_s2.message_done;

endmodule

`default_nettype wire
